// ===== rtl/sme_pkg.sv =====
// Package for the sorted multiset engine.
// Holds opcode, status and state codes plus the controller/datapath structs.
// No dependencies.
package sme_pkg;

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_REMOVE = 3'd1,
      OP_MEMBER = 3'd2,
      OP_PRED   = 3'd3,
      OP_SUCC   = 3'd4,
      OP_RANGE  = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE    = 2'd0,
      S_COMPARE = 2'd1,
      S_EXEC    = 2'd2
   } state_type;

   typedef struct packed {
      logic capture;
      logic compare;
      logic execute;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic op_range;
      logic range_done;
   } ctrl_status_type;

endpackage

// ===== rtl/sme_req_if.sv =====
// Request channel of the sorted multiset engine.
// Carries valid, ready and the request payload; no dependencies.
interface sme_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         opcode;
   logic signed [31:0] key;
   logic signed [31:0] key_high;

   modport source (output valid, output opcode, output key, output key_high, input ready);
   modport sink   (input valid, input opcode, input key, input key_high, output ready);
endinterface

// ===== rtl/sme_rsp_if.sv =====
// Response channel of the sorted multiset engine.
// Carries valid, ready and the response payload; no dependencies.
interface sme_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic               found;
   logic [1:0]         status;
   logic               last;

   modport source (output valid, output value, output found, output status, output last,
                   input ready);
   modport sink   (input valid, input value, input found, input status, input last,
                   output ready);
endinterface

// ===== rtl/sme_ctrl.sv =====
// Controller state machine of the sorted multiset engine.
// Sequences capture, compare and execute; uses sme_pkg.
module sme_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  sme_pkg::ctrl_status_type stat,
   output sme_pkg::ctrl_cmd_type    cmd,
   output logic                     req_ready
);

   sme_pkg::state_type state_ff;
   sme_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sme_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         sme_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sme_pkg::S_COMPARE;
            end
         end
         sme_pkg::S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = sme_pkg::S_EXEC;
         end
         sme_pkg::S_EXEC: begin
            if (stat.out_free) begin
               cmd.execute = 1'b1;
               if (!stat.op_range || stat.range_done) begin
                  state_in = sme_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = sme_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/sme_datapath.sv =====
// Datapath of the sorted multiset engine: key cell row, compare banks,
// read port and response register. Uses sme_pkg.
module sme_datapath #(
   parameter int CAPACITY = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sme_pkg::ctrl_cmd_type    cmd,
   output sme_pkg::ctrl_status_type stat,
   input  logic [2:0]               req_opcode,
   input  logic signed [31:0]       req_key,
   input  logic signed [31:0]       req_key_high,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic signed [31:0]       rsp_value,
   output logic                     rsp_found,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   logic [2:0]         op_ff;
   logic signed [31:0] key_ff;
   logic signed [31:0] key_high_ff;
   logic signed [31:0] keys_ff [CAPACITY];
   logic signed [31:0] keys_in [CAPACITY];
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [CW-1:0]      below_ff;
   logic [CW-1:0]      notabove_ff;
   logic [CW-1:0]      notabove_hi_ff;
   logic [CW-1:0]      scan_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] value_ff;
   logic               found_ff;
   logic [1:0]         status_ff;
   logic               last_ff;
   logic signed [31:0] value_in;
   logic               found_in;
   logic [1:0]         status_in;
   logic               last_in;

   logic [CAPACITY-1:0] lt_key;
   logic [CAPACITY-1:0] le_key;
   logic [CAPACITY-1:0] le_key_high;
   logic [CW-1:0]       rd_addr;
   logic signed [31:0]  rd_data;
   logic                is_member;
   logic                is_full;
   logic                range_hit;
   logic                range_done;

   function automatic logic [CW-1:0] therm_count(input logic [CAPACITY-1:0] t);
      logic [CW-1:0] pos;
      logic          lo;
      logic          hi;
      pos = '0;
      for (int i = 0; i <= CAPACITY; i++) begin
         lo = (i == 0) ? 1'b1 : t[i-1];
         hi = (i == CAPACITY) ? 1'b0 : t[i];
         if (lo && !hi) begin
            pos = pos | CW'(i);
         end
      end
      return pos;
   endfunction

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lt_key[i]      = (CW'(i) < count_ff) && (keys_ff[i] < key_ff);
         le_key[i]      = (CW'(i) < count_ff) && (keys_ff[i] <= key_ff);
         le_key_high[i] = (CW'(i) < count_ff) && (keys_ff[i] <= key_high_ff);
      end
   end

   always_comb begin
      case (op_ff)
         sme_pkg::OP_PRED: rd_addr = below_ff - CW'(1);
         sme_pkg::OP_SUCC: rd_addr = notabove_ff;
         default:          rd_addr = scan_ff;
      endcase
   end

   assign rd_data    = keys_ff[rd_addr[IW-1:0]];
   assign is_member  = notabove_ff > below_ff;
   assign is_full    = count_ff == CW'(CAPACITY);
   assign range_hit  = scan_ff < notabove_hi_ff;
   assign range_done = ({1'b0, scan_ff} + (CW+1)'(1)) >= {1'b0, notabove_hi_ff};

   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.op_range   = op_ff == sme_pkg::OP_RANGE;
   assign stat.range_done = range_done;

   always_comb begin
      keys_in   = keys_ff;
      count_in  = count_ff;
      value_in  = '0;
      found_in  = 1'b0;
      status_in = sme_pkg::ST_OK;
      last_in   = 1'b1;
      case (op_ff)
         sme_pkg::OP_INSERT: begin
            if (is_full) begin
               status_in = sme_pkg::ST_FULL;
            end else begin
               for (int i = 0; i < CAPACITY; i++) begin
                  if (CW'(i) == notabove_ff) begin
                     keys_in[i] = key_ff;
                  end else if (i > 0 && CW'(i) > notabove_ff) begin
                     keys_in[i] = keys_ff[(i > 0) ? i - 1 : 0];
                  end
               end
               count_in = count_ff + CW'(1);
            end
         end
         sme_pkg::OP_REMOVE: begin
            if (is_member) begin
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (CW'(i) >= below_ff) begin
                     keys_in[i] = keys_ff[i+1];
                  end
               end
               count_in = count_ff - CW'(1);
               found_in = 1'b1;
            end else begin
               status_in = sme_pkg::ST_NOT_FOUND;
            end
         end
         sme_pkg::OP_MEMBER: begin
            found_in = is_member;
         end
         sme_pkg::OP_PRED: begin
            if (below_ff != '0) begin
               value_in = rd_data;
               found_in = 1'b1;
            end
         end
         sme_pkg::OP_SUCC: begin
            if (notabove_ff < count_ff) begin
               value_in = rd_data;
               found_in = 1'b1;
            end
         end
         sme_pkg::OP_RANGE: begin
            if (range_hit) begin
               value_in = rd_data;
               found_in = 1'b1;
            end
            last_in = range_done;
         end
         default: begin
            value_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.execute) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_opcode;
         key_ff      <= req_key;
         key_high_ff <= req_key_high;
      end
      if (cmd.compare) begin
         below_ff       <= therm_count(lt_key);
         notabove_ff    <= therm_count(le_key);
         notabove_hi_ff <= therm_count(le_key_high);
         scan_ff        <= therm_count(lt_key);
      end
      if (cmd.execute) begin
         keys_ff   <= keys_in;
         value_ff  <= value_in;
         found_ff  <= found_in;
         status_ff <= status_in;
         last_ff   <= last_in;
         scan_ff   <= scan_ff + CW'(1);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = value_ff;
   assign rsp_found  = found_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;

endmodule

// ===== rtl/sorted_multiset_engine.sv =====
// Sorted multiset engine: a bounded, ascending table of signed 32-bit keys
// with duplicates, serving insert, remove, member, strict predecessor, strict
// successor and inclusive range requests. Each request is taken in the idle
// cycle, compared against every held key at once in the next cycle, and its
// result is registered in the execute state once the response slot is free;
// a range request gives one response per result (an empty range gives one),
// and each request waits while the response side stalls. The compare bank
// is registered, and the single read port of the key row yields one range
// key per cycle while the response side does not stall. The table is empty
// after reset.
// Uses sme_pkg, sme_req_if, sme_rsp_if, sme_ctrl and sme_datapath.
module sorted_multiset_engine #(
   parameter int CAPACITY = 32
) (
   input  logic         clock,
   input  logic         reset,
   sme_req_if.sink      req_ch,
   sme_rsp_if.source    rsp_ch
);

   sme_pkg::ctrl_cmd_type    cmd;
   sme_pkg::ctrl_status_type stat;
   logic                     req_ready;

   sme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   sme_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_opcode   (req_ch.opcode),
      .req_key      (req_ch.key),
      .req_key_high (req_ch.key_high),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_value    (rsp_ch.value),
      .rsp_found    (rsp_ch.found),
      .rsp_status   (rsp_ch.status),
      .rsp_last     (rsp_ch.last)
   );

   assign req_ch.ready = req_ready;

endmodule

// ===== rtl/sme_checker.sv =====
// Port-level checks for the sorted multiset engine, bound to the top level.
// Uses sme_pkg status codes.
module sme_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_value,
   input logic               rsp_found,
   input logic [1:0]         rsp_status,
   input logic               rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_found)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("response changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sme_pkg::ST_OK |-> !rsp_found && rsp_last)
      else $error("error response with found set or not last");

   a_value_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_value == '0)
      else $error("value without found flag");

endmodule

bind sorted_multiset_engine sme_checker u_sme_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_value  (rsp_ch.value),
   .rsp_found  (rsp_ch.found),
   .rsp_status (rsp_ch.status),
   .rsp_last   (rsp_ch.last)
);
